// ===== hw/rtl/pcld_pkg.sv =====
// ---------------------------------------------------------------------------
// Prefix-code letter decoder package
// Shared widths, word types and the code-to-letter mapping.
// ---------------------------------------------------------------------------
package pcld_pkg;

	localparam int COUNT_BITS = 16;
	localparam int CFG_BITS   = 16;
	localparam int BUF_BITS   = 13;
	localparam int HELD_BITS  = 4;

	localparam logic [HELD_BITS-1:0] HELD_MAX    = HELD_BITS'(BUF_BITS);
	localparam logic [6:0]           LETTER_BASE = 7'd97;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       start_req;
	} pcld_in_t;

	typedef struct packed {
		logic [6:0] letter;
		logic       bad_code;
		logic       last_of_byte;
		logic       last_of_message;
	} pcld_out_t;

	// Letter offset of the first code in each group: 2^(g+1) - 2.
	function automatic logic [3:0] pcld_group_base(input logic [1:0] g);
		logic [3:0] base;
		unique case (g)
			2'd0: base = 4'd0;
			2'd1: base = 4'd2;
			2'd2: base = 4'd6;
			default: base = 4'd14;
		endcase
		return base;
	endfunction

	// Mask of the g+1 index bits.
	function automatic logic [3:0] pcld_index_mask(input logic [1:0] g);
		logic [3:0] mask;
		unique case (g)
			2'd0: mask = 4'b0001;
			2'd1: mask = 4'b0011;
			2'd2: mask = 4'b0111;
			default: mask = 4'b1111;
		endcase
		return mask;
	endfunction

endpackage

// ===== hw/rtl/prefix_code_letter_decoder_core.sv =====
// ---------------------------------------------------------------------------
// Prefix-code letter decoder core
// Turns a stream of ciphertext bytes into letters of a small prefix code.
// ---------------------------------------------------------------------------
// Each input word carries one ciphertext byte, read least significant bit
// first, and a start flag that opens a new message before the byte is used.
// A code is a two-bit group g followed by g+1 index bits; it decodes to the
// letter 'a' + 2^(g+1) - 2 + index, so group 3 indices twelve to fifteen give
// codes above 'z', which are passed on with bad_code set. Bits that do not
// complete a code are held over to the next byte, and one byte gives from
// none to four letters, each as an output word of its own; last_of_byte marks
// the final letter of a byte and last_of_message the letter that reaches the
// configured count, after which bytes give no letters until the next start.
// Timing: a byte is taken while the unpacker is idle and its letters are then
// produced by the unpacker's shift register at one letter a cycle, as long as
// out_ready does not hold the output off; the input is ready again only once
// the byte's last letter is handed over, or once the unpacker finds no whole
// code in a byte that yields none. A finished result sits in the output register
// while the unpacker carries on. The character count register is written
// through the configuration channel, which is always ready; it may only be
// changed while the block is idle.
// ---------------------------------------------------------------------------
module prefix_code_letter_decoder_core import pcld_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pcld_in_t            in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pcld_out_t           out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_BITS-1:0] cfg_data
);

	// Number of letters in one message.
	logic [CFG_BITS-1:0] char_count_q;

	// Handshake between the unpacker and the output register.
	logic      res_valid;
	logic      res_ready;
	pcld_out_t res_data;

	// Output register: one word, refilled in the cycle it is taken.
	logic      out_valid_q;
	pcld_out_t out_data_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= '0;
		end else if (cfg_valid) begin
			char_count_q <= cfg_data;
		end
	end

	pcld_unpack u_unpack (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.char_count (char_count_q),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data)
	);

	// The unpacker may hand over a new letter whenever the register is empty
	// or its current word leaves in this cycle.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	// Payload needs no reset: it is only looked at while out_valid is high.
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_data_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== hw/rtl/pcld_unpack.sv =====
// ---------------------------------------------------------------------------
// Prefix-code letter decoder bit unpacker
// Holds the pending bits as a shift register and peels off one code a cycle while the output takes it.
// ---------------------------------------------------------------------------
module pcld_unpack import pcld_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  pcld_in_t        in_data,
	input  logic [CFG_BITS-1:0] char_count,
	output logic            res_valid,
	input  logic            res_ready,
	output pcld_out_t       res_data
);

	typedef enum logic {ST_IDLE, ST_DECODE} state_t;

	state_t                 state_q;
	logic [BUF_BITS-1:0]    buf_q;
	logic [HELD_BITS-1:0]   held_q;
	logic [COUNT_BITS-1:0]  done_q;
	logic                   fin_q;
	logic [1:0]             n_q;

	logic [COUNT_BITS-1:0]  target;
	logic [BUF_BITS-1:0]    eff_buf;
	logic [HELD_BITS-1:0]   eff_held;
	logic [COUNT_BITS-1:0]  eff_done;
	logic                   eff_fin;
	logic [BUF_BITS-1:0]    ld_wide;
	logic [BUF_BITS-1:0]    ld_buf;
	logic [HELD_BITS:0]     ld_sum;
	logic [HELD_BITS-1:0]   ld_held;

	logic [1:0]             grp;
	logic [HELD_BITS-1:0]   code_len;
	logic                   code_ok;
	logic [3:0]             idx;
	logic [BUF_BITS-1:0]    nxt_buf;
	logic [HELD_BITS-1:0]   nxt_held;
	logic                   nxt_ok;
	logic [COUNT_BITS-1:0]  done_inc;
	logic                   last_msg;
	logic                   last_byte;

	always_comb begin
		target   = COUNT_BITS'(char_count);
		eff_buf  = in_data.start_req ? '0 : buf_q;
		eff_held = in_data.start_req ? '0 : held_q;
		eff_done = in_data.start_req ? '0 : done_q;
		eff_fin  = in_data.start_req ? 1'b0 : fin_q;
		ld_wide  = BUF_BITS'(in_data.in_byte) << eff_held;
		ld_buf   = eff_buf | ld_wide;
		ld_sum   = (HELD_BITS+1)'(eff_held) + (HELD_BITS+1)'(8);
		ld_held  = (ld_sum > (HELD_BITS+1)'(HELD_MAX)) ? HELD_MAX : ld_sum[HELD_BITS-1:0];

		grp      = buf_q[1:0];
		code_len = HELD_BITS'(grp) + HELD_BITS'(3);
		code_ok  = held_q >= code_len;
		idx      = buf_q[5:2] & pcld_index_mask(grp);
		nxt_buf  = buf_q >> code_len;
		nxt_held = held_q - code_len;
		nxt_ok   = nxt_held >= (HELD_BITS'(nxt_buf[1:0]) + HELD_BITS'(3));
		done_inc = done_q + COUNT_BITS'(1);
		last_msg = done_inc == target;
		last_byte = !nxt_ok || (n_q == 2'd3) || last_msg;

		in_ready  = state_q == ST_IDLE;
		res_valid = (state_q == ST_DECODE) && code_ok;
		res_data.letter          = LETTER_BASE + 7'(pcld_group_base(grp)) + 7'(idx);
		res_data.bad_code        = (grp == 2'd3) && (idx > 4'd11);
		res_data.last_of_byte    = last_byte;
		res_data.last_of_message = last_msg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			buf_q   <= '0;
			held_q  <= '0;
			done_q  <= '0;
			fin_q   <= 1'b0;
			n_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (eff_fin) begin
							buf_q  <= eff_buf;
							held_q <= eff_held;
							done_q <= eff_done;
							fin_q  <= eff_fin;
						end else if (eff_done >= target) begin
							buf_q  <= '0;
							held_q <= '0;
							done_q <= eff_done;
							fin_q  <= 1'b1;
						end else begin
							buf_q   <= ld_buf;
							held_q  <= ld_held;
							done_q  <= eff_done;
							fin_q   <= 1'b0;
							n_q     <= '0;
							state_q <= ST_DECODE;
						end
					end
				end
				ST_DECODE: begin
					if (!code_ok) begin
						state_q <= ST_IDLE;
					end else if (res_ready) begin
						buf_q  <= nxt_buf;
						held_q <= nxt_held;
						done_q <= done_inc;
						n_q    <= n_q + 2'd1;
						if (last_msg) begin
							fin_q  <= 1'b1;
							buf_q  <= '0;
							held_q <= '0;
						end
						if (last_byte) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The pending count never exceeds the buffer width.
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HELD_MAX)
		else $error("pending bit count beyond buffer width");

	// A letter is only offered when at least a shortest code is pending.
	a_code_bits: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> held_q >= HELD_BITS'(3))
		else $error("letter offered without enough pending bits");

	// A finished message holds no pending bits while waiting for a byte.
	a_fin_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_q && state_q == ST_IDLE) |-> held_q == '0)
		else $error("finished message still holds bits");

	// The closing letter of a message returns the unpacker to idle, finished.
	a_msg_close: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && last_msg) |=> (fin_q && state_q == ST_IDLE))
		else $error("message did not close after its last letter");

endmodule

// ===== tb/tb_prefix_code_letter_decoder_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the prefix-code letter decoder core
// Drives ciphertext bytes and character counts into the core and checks each
// letter word against a cycle-free model of the decoder held in the bench.
// ---------------------------------------------------------------------------
// A short table of directed bytes comes first: the zero count, the extreme
// byte values, bad codes, the count being reached, raised and lowered, and a
// start flag arriving with a byte. Random phases follow, each under its own
// character count, with random gaps on both channels and one long output
// stall that backs the core up into its input. Letters are compared field by
// field, in order, with the words the model expects.
// ---------------------------------------------------------------------------
module tb_prefix_code_letter_decoder_core;
	import pcld_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 7;
	localparam int DRAIN_CYCLES = 8;
	localparam int LIMIT_CYCLES = 300000;
	localparam int PHASES       = 8;
	localparam int PHASE_BYTES  = 44;
	localparam int STALL_AFTER  = 150;
	localparam int STALL_CYCLES = 400;
	localparam int DIR_ROWS     = 23;

	// One row of the directed table. When fixed is set, the letters are typed
	// in (at most two of them); otherwise the model supplies them.
	typedef struct packed {
		logic            do_cfg;
		logic [15:0]     cfg_val;
		logic [7:0]      byte_v;
		logic            start_req;
		logic            fixed;
		logic [1:0]      fixed_n;
		pcld_out_t       r0;
		pcld_out_t       r1;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	pcld_in_t            in_data;
	logic                out_valid;
	logic                out_ready;
	pcld_out_t           out_data;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_BITS-1:0] cfg_data;

	// Model state: pending code bits, how many of them are valid, letters
	// produced in the current message and whether the message is over.
	logic [BUF_BITS-1:0]   pend_bits;
	int unsigned           pend_cnt;
	logic [COUNT_BITS-1:0] letters_done;
	logic                  msg_closed;
	logic [CFG_BITS-1:0]   char_count;

	pcld_out_t letters_due[$];
	pcld_out_t byte_letters[$];
	dir_row_t  dir_rows [DIR_ROWS];

	bit idle_on;
	int words_taken;
	int live_bytes;
	int letters_seen;
	int cfg_writes;
	int fails;
	int cycle_count;

	prefix_code_letter_decoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timed out after %0d cycles with %0d letters outstanding.",
				cycle_count, letters_due.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic pcld_out_t mk_letter(input int ltr, input bit bad, input bit lb,
		input bit lm);
		pcld_out_t w;
		w.letter          = 7'(ltr);
		w.bad_code        = bad;
		w.last_of_byte    = lb;
		w.last_of_message = lm;
		return w;
	endfunction

	// Decodes one accepted byte into byte_letters and updates the model state.
	// live is cleared when the message was already over and the byte is dropped.
	task automatic decode_byte(input pcld_in_t w, output bit live);
		logic [31:0] acc;
		int unsigned g;
		int unsigned len;
		int unsigned idx;
		int          n;
		bit          reached;
		n = 0;
		byte_letters.delete();
		if (w.start_req) begin
			pend_bits    = '0;
			pend_cnt     = 0;
			letters_done = '0;
			msg_closed   = 1'b0;
		end
		live = !msg_closed;
		if (msg_closed)
			return;
		// The count may already be met, for instance after it was lowered.
		if (letters_done >= char_count) begin
			msg_closed = 1'b1;
			pend_bits  = '0;
			pend_cnt   = 0;
			return;
		end
		acc       = 32'(pend_bits) | (32'(w.in_byte) << pend_cnt);
		pend_bits = acc[BUF_BITS-1:0];
		pend_cnt  = (pend_cnt + 8 > BUF_BITS) ? BUF_BITS : pend_cnt + 8;
		while (n < 4 && pend_cnt >= 2) begin
			g   = 32'(pend_bits[1:0]);
			len = 3 + g;
			if (pend_cnt < len)
				break;
			idx          = (32'(pend_bits) >> 2) & ((1 << (g + 1)) - 1);
			pend_bits    = pend_bits >> len;
			pend_cnt     = pend_cnt - len;
			letters_done = letters_done + COUNT_BITS'(1);
			reached      = (letters_done == char_count);
			byte_letters.push_back(mk_letter(97 + (1 << (g + 1)) - 2 + idx,
				g == 3 && idx > 11, 1'b0, reached));
			n++;
			if (reached) begin
				msg_closed = 1'b1;
				pend_bits  = '0;
				pend_cnt   = 0;
				break;
			end
		end
		if (n > 0)
			byte_letters[n-1].last_of_byte = 1'b1;
	endtask

	// Offers one byte, holding it until the core takes it, then runs the model.
	task automatic offer_byte(input pcld_in_t w, output bit live);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		words_taken++;
		decode_byte(w, live);
		if (live)
			live_bytes++;
	endtask

	// The count is only changed with the core idle: every expected letter in,
	// and then a drain wait for a byte that may still be closing a message.
	task automatic write_char_count(input logic [CFG_BITS-1:0] v);
		in_valid <= 1'b0;
		while (letters_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		char_count = v;
		cfg_writes++;
		cfg_valid <= 1'b0;
	endtask

	// Output side: random hold-offs, plus one long stall once the traffic is
	// well under way so that the core fills and pushes back on its input.
	initial begin
		bit stalled;
		stalled = 1'b0;
		out_ready <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (!stalled && words_taken >= STALL_AFTER) begin
				stalled = 1'b1;
				out_ready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	// Every letter word is checked against the oldest expectation.
	always @(posedge clk) begin
		pcld_out_t want;
		if (arst_n && out_valid && out_ready) begin
			letters_seen++;
			if (letters_due.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("Unexpected letter word: letter %0d bad %b lob %b lom %b",
						out_data.letter, out_data.bad_code, out_data.last_of_byte,
						out_data.last_of_message);
			end else begin
				want = letters_due.pop_front();
				if (want.letter != out_data.letter || want.bad_code != out_data.bad_code ||
					want.last_of_byte != out_data.last_of_byte ||
					want.last_of_message != out_data.last_of_message) begin
					fails++;
					if (fails <= 10)
						$display("Letter %0d mismatch: expected %0d/%b/%b/%b, got %0d/%b/%b/%b",
							letters_seen, want.letter, want.bad_code, want.last_of_byte,
							want.last_of_message, out_data.letter, out_data.bad_code,
							out_data.last_of_byte, out_data.last_of_message);
				end
			end
		end
	end

	initial begin
		pcld_out_t             nil;
		pcld_in_t              w;
		bit                    live;
		int                    got;
		logic [CFG_BITS-1:0]   phase_count [PHASES];
		nil = '0;
		pend_bits    = '0;
		pend_cnt     = 0;
		letters_done = '0;
		msg_closed   = 1'b0;
		char_count   = '0;
		idle_on      = 1'b1;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;

		// Directed words. Group-3 bytes: 0x33, 0x37 and 0x3B carry the bad
		// indices twelve to fourteen, 0xFF carries fifteen and 0x2F gives 'z'.
		dir_rows = '{
			'{1'b1, 16'h0000, 8'hA5, 1'b1, 1'b1, 2'd0, nil, nil},
			'{1'b0, 16'h0000, 8'h00, 1'b0, 1'b1, 2'd0, nil, nil},
			'{1'b1, 16'hFFFF, 8'h00, 1'b1, 1'b1, 2'd2,
				mk_letter(97, 0, 0, 0), mk_letter(97, 0, 1, 0)},
			'{1'b0, 16'h0000, 8'hFF, 1'b1, 1'b1, 2'd1, mk_letter(126, 1, 1, 0), nil},
			'{1'b0, 16'h0000, 8'h33, 1'b1, 1'b1, 2'd1, mk_letter(123, 1, 1, 0), nil},
			'{1'b0, 16'h0000, 8'h37, 1'b1, 1'b0, 2'd0, nil, nil},
			'{1'b0, 16'h0000, 8'h3B, 1'b1, 1'b0, 2'd0, nil, nil},
			'{1'b0, 16'h0000, 8'h2F, 1'b1, 1'b0, 2'd0, nil, nil},
			'{1'b0, 16'h0000, 8'h5A, 1'b0, 1'b0, 2'd0, nil, nil},
			'{1'b0, 16'h0000, 8'hC3, 1'b0, 1'b0, 2'd0, nil, nil},
			'{1'b0, 16'h0000, 8'h96, 1'b0, 1'b0, 2'd0, nil, nil},
			'{1'b0, 16'h0000, 8'h0F, 1'b0, 1'b0, 2'd0, nil, nil},
			'{1'b0, 16'h0000, 8'hF0, 1'b0, 1'b0, 2'd0, nil, nil},
			'{1'b1, 16'h0001, 8'h00, 1'b1, 1'b1, 2'd1, mk_letter(97, 0, 1, 1), nil},
			'{1'b0, 16'h0000, 8'h55, 1'b0, 1'b1, 2'd0, nil, nil},
			'{1'b1, 16'h0003, 8'hFF, 1'b0, 1'b1, 2'd0, nil, nil},
			'{1'b0, 16'h0000, 8'h00, 1'b1, 1'b0, 2'd0, nil, nil},
			'{1'b0, 16'h0000, 8'h00, 1'b0, 1'b0, 2'd0, nil, nil},
			'{1'b1, 16'hFFFF, 8'h12, 1'b1, 1'b0, 2'd0, nil, nil},
			'{1'b0, 16'h0000, 8'h34, 1'b0, 1'b0, 2'd0, nil, nil},
			'{1'b0, 16'h0000, 8'h56, 1'b0, 1'b0, 2'd0, nil, nil},
			'{1'b1, 16'h0002, 8'h9A, 1'b0, 1'b1, 2'd0, nil, nil},
			'{1'b0, 16'h0000, 8'h00, 1'b1, 1'b0, 2'd0, nil, nil}
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Row one runs with the count still zero from reset and
		// writes zero again; the count is later raised on a finished message
		// and lowered below the letters already produced.
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (dir_rows[r].do_cfg)
				write_char_count(dir_rows[r].cfg_val);
			w.in_byte   = dir_rows[r].byte_v;
			w.start_req = dir_rows[r].start_req;
			offer_byte(w, live);
			if (dir_rows[r].fixed) begin
				if (dir_rows[r].fixed_n > 0)
					letters_due.push_back(dir_rows[r].r0);
				if (dir_rows[r].fixed_n > 1)
					letters_due.push_back(dir_rows[r].r1);
			end else begin
				foreach (byte_letters[i])
					letters_due.push_back(byte_letters[i]);
			end
		end

		// Random phases, each under its own count; the last runs without gaps.
		phase_count[0] = 16'd1;
		phase_count[1] = 16'd2;
		phase_count[2] = 16'hFFFF;
		phase_count[3] = 16'd5;
		phase_count[4] = 16'($urandom_range(3, 30));
		phase_count[5] = 16'($urandom_range(1, 65535));
		phase_count[6] = 16'd9;
		phase_count[7] = 16'($urandom_range(1, 4));
		for (int ph = 0; ph < PHASES; ph++) begin
			write_char_count(phase_count[ph]);
			if (ph == PHASES - 1)
				idle_on = 1'b0;
			got = 0;
			while (got < PHASE_BYTES) begin
				if ($urandom_range(0, 7) == 0)
					w.in_byte = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				else
					w.in_byte = 8'($urandom_range(0, 255));
				// A finished message is mostly restarted; now and then a byte is
				// sent into it anyway, and an open one is restarted only rarely.
				if (msg_closed || letters_done >= char_count)
					w.start_req = ($urandom_range(0, 3) != 0);
				else
					w.start_req = ($urandom_range(0, 39) == 0);
				offer_byte(w, live);
				foreach (byte_letters[i])
					letters_due.push_back(byte_letters[i]);
				if (live)
					got++;
			end
		end

		in_valid <= 1'b0;
		while (letters_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d bytes (%0d in open messages) and %0d letter words,",
			words_taken, live_bytes, letters_seen);
		$display("under %0d count settings, with gaps, one long output stall and a gap-free end.",
			cfg_writes);
		if (fails == 0 && letters_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d failures, %0d letters never arrived.", fails, letters_due.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
